@@ rtl/core/v3n_pkg.sv @@
package v3n_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 14;

	// Pipeline-wide status carried alongside each item.
	typedef struct packed {
		logic valid;
		logic zero;
	} v3n_ctl_t;

endpackage

@@ rtl/core/v3n_if.sv @@
interface v3n_if #(
	parameter int W = 16
) (
	input logic clk
);
	logic         valid;
	logic         ready;
	logic [W-1:0] x;
	logic [W-1:0] y;
	logic [W-1:0] z;
	logic         zero;

	modport source (output valid, x, y, z, zero, input ready);
	modport sink   (input valid, x, y, z, zero, output ready);
endinterface

@@ rtl/core/v3n_sqrt.sv @@
// Pipelined integer square root: one result bit per stage.
module v3n_sqrt
	import v3n_pkg::*;
#(
	parameter int SW = 34,
	parameter int RW = 17,
	parameter int CW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [SW-1:0] s,
	input  logic [CW-1:0] side_in,
	output logic [RW-1:0] root,
	output logic [CW-1:0] side_out
);
	localparam int RMW = RW + 2;

	logic [SW-1:0]  rem_r  [RW+1];
	logic [RW-1:0]  root_r [RW+1];
	logic [CW-1:0]  side_r [RW+1];

	assign rem_r[0]  = s;
	assign root_r[0] = '0;
	assign side_r[0] = side_in;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		logic [SW-1:0]  rem_q;
		logic [RW-1:0]  root_q;
		logic [CW-1:0]  side_q;
		logic [RMW-1:0] top;
		logic [RMW-1:0] trial;

		// Remainder bits from 2B upward are compared with 4*root + 1 shifted.
		always_comb begin
			top   = RMW'(rem_r[k] >> (2 * B));
			trial = {root_r[k], 2'b01};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q <= side_r[k];
				if (top >= trial) begin
					rem_q  <= rem_r[k] - (SW'(trial) << (2 * B));
					root_q <= {root_r[k][RW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_r[k];
					root_q <= {root_r[k][RW-2:0], 1'b0};
				end
			end
		end
		assign rem_r[k+1]  = rem_q;
		assign root_r[k+1] = root_q;
		assign side_r[k+1] = side_q;
	end

	assign root     = root_r[RW];
	assign side_out = side_r[RW];
endmodule

@@ rtl/core/v3n_div_lane.sv @@
// One lane: restoring divider, one quotient bit per stage, then saturate and apply the sign.
module v3n_div_lane
	import v3n_pkg::*;
#(
	parameter int MW = 16,
	parameter int DW = 17,
	parameter int FB = 14
) (
	input  logic          clk,
	input  logic          en,
	input  logic [MW-1:0] mag,
	input  logic          neg,
	input  logic [DW-1:0] m,
	output logic [FB+1:0] unit
);
	localparam int NW = MW + FB;
	localparam int RW = DW + 1;

	logic [NW-1:0] num_r [NW+1];
	logic [RW-1:0] rem_r [NW+1];
	logic [NW-1:0] quo_r [NW+1];
	logic [DW-1:0] den_r [NW+1];
	logic          neg_r [NW+1];

	assign num_r[0] = {mag, FB'(0)};
	assign rem_r[0] = '0;
	assign quo_r[0] = '0;
	assign den_r[0] = m;
	assign neg_r[0] = neg;

	for (genvar k = 0; k < NW; k++) begin : g_bit
		logic [RW-1:0] sh;
		logic [NW-1:0] num_q, quo_q;
		logic [RW-1:0] rem_q;
		logic [DW-1:0] den_q;
		logic          neg_q;

		assign sh = {rem_r[k][RW-2:0], num_r[k][NW-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				num_q <= num_r[k] << 1;
				den_q <= den_r[k];
				neg_q <= neg_r[k];
				if (sh >= {1'b0, den_r[k]}) begin
					rem_q <= sh - {1'b0, den_r[k]};
					quo_q <= {quo_r[k][NW-2:0], 1'b1};
				end else begin
					rem_q <= sh;
					quo_q <= {quo_r[k][NW-2:0], 1'b0};
				end
			end
		end
		assign num_r[k+1] = num_q;
		assign rem_r[k+1] = rem_q;
		assign quo_r[k+1] = quo_q;
		assign den_r[k+1] = den_q;
		assign neg_r[k+1] = neg_q;
	end

	logic [FB+1:0] sat;

	// Saturate to one, then apply the sign.
	always_comb begin
		if (quo_r[NW] > NW'(1 << FB))
			sat = (FB+2)'(1 << FB);
		else
			sat = quo_r[NW][FB+1:0];
		unit = neg_r[NW] ? (~sat + 1'b1) : sat;
	end
endmodule

@@ rtl/core/vector3_normalizer.sv @@
// Channel  Dir  Payload                                      Handshake
// in_ch    in   x, y, z (SAMPLE_BITS, signed)                valid/ready
// out_ch   out  x, y, z (FRACTION_BITS+2, signed), zero      valid/ready
//
// One item is accepted every cycle while the pipeline advances; each passes
// the magnitude and sum-of-squares registers, the bit-per-stage square root,
// the three divider lanes and the output register.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears only valid bits; payload registers are not reset.
module vector3_normalizer
	import v3n_pkg::*;
#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	v3n_if.sink   in_ch,
	v3n_if.source out_ch
);
	localparam int SW  = 2 * SAMPLE_BITS + 2;
	localparam int RTW = SAMPLE_BITS + 1;
	localparam int UW  = FRACTION_BITS + 2;
	localparam int LAT = 2 + RTW + SAMPLE_BITS + FRACTION_BITS;
	localparam int CW  = 1 + 3 * SAMPLE_BITS + 3;

	logic en;
	logic [LAT-1:0] vld_q;
	logic out_vld_q;

	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: magnitudes and signs.
	logic [SAMPLE_BITS-1:0] mag_s1 [3];
	logic                   neg_s1 [3];
	logic [SAMPLE_BITS-1:0] raw    [3];
	assign raw[0] = in_ch.x[SAMPLE_BITS-1:0];
	assign raw[1] = in_ch.y[SAMPLE_BITS-1:0];
	assign raw[2] = in_ch.z[SAMPLE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= raw[i][SAMPLE_BITS-1];
				mag_s1[i] <= raw[i][SAMPLE_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
			end
		end
	end

	// Stage 2: sum of squares.
	logic [SW-1:0]          s_s2;
	logic [CW-1:0]          side_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= SW'(mag_s1[0] * mag_s1[0]) + SW'(mag_s1[1] * mag_s1[1])
				+ SW'(mag_s1[2] * mag_s1[2]);
			side_s2 <= {1'b0, mag_s1[0], mag_s1[1], mag_s1[2],
				neg_s1[0], neg_s1[1], neg_s1[2]};
		end
	end

	logic [RTW-1:0] m_r;
	logic [CW-1:0]  side_r;
	logic [CW-1:0]  side_in;
	assign side_in = {(s_s2 == '0), side_s2[CW-2:0]};

	v3n_sqrt #(.SW(SW), .RW(RTW), .CW(CW)) u_sqrt (
		.clk(clk), .en(en), .s(s_s2),
		.side_in(side_in), .root(m_r), .side_out(side_r)
	);

	logic [SAMPLE_BITS-1:0] lmag [3];
	logic                   lneg [3];
	logic [UW-1:0]          lunit [3];
	assign lmag[0] = side_r[3+3*SAMPLE_BITS-1 -: SAMPLE_BITS];
	assign lmag[1] = side_r[3+2*SAMPLE_BITS-1 -: SAMPLE_BITS];
	assign lmag[2] = side_r[3+SAMPLE_BITS-1 -: SAMPLE_BITS];
	assign lneg[0] = side_r[2];
	assign lneg[1] = side_r[1];
	assign lneg[2] = side_r[0];

	// Three lanes divide in parallel; a zero root gives an all-ones quotient, masked later.
	for (genvar l = 0; l < 3; l++) begin : g_lane
		v3n_div_lane #(.MW(SAMPLE_BITS), .DW(RTW), .FB(FRACTION_BITS)) u_lane (
			.clk(clk), .en(en), .mag(lmag[l]), .neg(lneg[l]), .m(m_r), .unit(lunit[l])
		);
	end

	// Zero flag delayed to match the divider lanes.
	localparam int DL = SAMPLE_BITS + FRACTION_BITS;
	logic [DL-1:0] zero_q;
	always_ff @(posedge clk) begin
		if (en)
			zero_q <= {zero_q[DL-2:0], side_r[CW-1]};
	end

	// Merge stage: output register.
	v3n_ctl_t ctl;
	logic [UW-1:0] ux_q, uy_q, uz_q;
	assign ctl.valid = vld_q[LAT-1];
	assign ctl.zero  = zero_q[DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			ux_q <= ctl.zero ? '0 : lunit[0];
			uy_q <= ctl.zero ? '0 : lunit[1];
			uz_q <= ctl.zero ? '0 : lunit[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[LAT-2:0], in_ch.valid};
			out_vld_q <= ctl.valid;
		end
	end
	logic zero_o_q;
	always_ff @(posedge clk) begin
		if (en)
			zero_o_q <= ctl.zero;
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.x     = ux_q;
	assign out_ch.y     = uy_q;
	assign out_ch.z     = uz_q;
	assign out_ch.zero  = zero_o_q;

	// A waiting result is not lost while the pipeline stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_ch.ready |=> out_vld_q)
		else $error("result dropped during stall");
	// A zero vector gives zero components.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && zero_o_q |-> ux_q == '0 && uy_q == '0 && uz_q == '0)
		else $error("zero vector gave nonzero output");
	// The pipeline only advances when the output can take a result.
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
endmodule

@@ dv/vector3_normalizer_test.sv @@
module vector3_normalizer_test;
	import v3n_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int FB = FRACTION_BITS_DEF;
	localparam int UW = FB + 2;
	localparam int LATENCY = 2 + (SB + 1) + (SB + FB) + 1;
	localparam int ITEMS = 1200;

	// One normalised result as the block should present it.
	typedef struct packed {
		logic [UW-1:0] xu;
		logic [UW-1:0] yu;
		logic [UW-1:0] zu;
		logic          zero;
	} unit_vec_t;

	// Floor integer square root, bit by bit.
	function automatic longint unsigned floor_root(longint unsigned s);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned b;
		rem = s;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// Scales one magnitude by 2^FB / m, saturates and restores the sign.
	function automatic logic [UW-1:0] scale_axis(longint unsigned mag, bit neg,
		longint unsigned m);
		longint unsigned q;
		q = (mag << FB) / m;
		if (q > (64'd1 << FB))
			q = 64'd1 << FB;
		if (neg)
			q = ~q + 1;
		return q[UW-1:0];
	endfunction

	// Works out the unit vector of one sample.
	function automatic unit_vec_t unit_of(logic [SB-1:0] x, logic [SB-1:0] y,
		logic [SB-1:0] z);
		logic [SB-1:0]   c [3];
		longint unsigned mag [3];
		bit              neg [3];
		longint unsigned s;
		longint unsigned m;
		unit_vec_t       r;
		c[0] = x;
		c[1] = y;
		c[2] = z;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i][SB-1];
			mag[i] = neg[i] ? longint'((~c[i] + 1'b1) & {SB{1'b1}}) : longint'(c[i]);
			if (neg[i] && c[i] == {1'b1, {(SB-1){1'b0}}})
				mag[i] = 64'd1 << (SB - 1);
			s += mag[i] * mag[i];
		end
		r = '0;
		if (s == 0) begin
			r.zero = 1'b1;
			return r;
		end
		m = floor_root(s);
		r.xu = scale_axis(mag[0], neg[0], m);
		r.yu = scale_axis(mag[1], neg[1], m);
		r.zu = scale_axis(mag[2], neg[2], m);
		return r;
	endfunction

	// Holds the unit vectors still owed by the block and compares arrivals.
	class unit_vector_board;
		unit_vec_t owed [$];
		int        errors;

		function void note_sample(logic [SB-1:0] x, logic [SB-1:0] y, logic [SB-1:0] z);
			owed = {owed, unit_of(x, y, z)};
		endfunction

		function void check_result(unit_vec_t got);
			unit_vec_t want;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result x=%h y=%h z=%h zero=%b",
						got.xu, got.yu, got.zu, got.zero);
				return;
			end
			want = owed.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected x=%h y=%h z=%h zero=%b, got x=%h y=%h z=%h zero=%b",
						want.xu, want.yu, want.zu, want.zero,
						got.xu, got.yu, got.zu, got.zero);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   hold_req;

	unit_vector_board board;

	v3n_if #(.W(SB)) samples (.clk(clk));
	v3n_if #(.W(UW)) units (.clk(clk));

	vector3_normalizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(samples.sink),
		.out_ch(units.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offers one sample and waits for its transfer.
	task automatic send_sample(logic [SB-1:0] x, logic [SB-1:0] y, logic [SB-1:0] z);
		if (!calm) begin
			while ($urandom_range(99) < 11) begin
				samples.valid <= 1'b0;
				@(posedge clk);
			end
		end
		samples.valid <= 1'b1;
		samples.x <= x;
		samples.y <= y;
		samples.z <= z;
		do
			@(posedge clk);
		while (!samples.ready);
		board.note_sample(x, y, z);
	endtask

	// Picks one random axis value, often small so that ratios vary widely.
	function automatic logic [SB-1:0] pick_axis();
		case ($urandom_range(5))
			0: return '0;
			1: return SB'($signed($urandom_range(16)) - 8);
			2: return SB'($signed($urandom_range(2000)) - 1000);
			default: return SB'($urandom);
		endcase
	endfunction

	// Stimulus: directed corners first, then random samples.
	initial begin
		logic [SB-1:0] corner [20][3];
		board = new();
		arst_n = 1'b0;
		samples.valid <= 1'b0;
		samples.x <= '0;
		samples.y <= '0;
		samples.z <= '0;
		samples.zero <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		corner = '{
			'{16'h0000, 16'h0000, 16'h0000}, '{16'h8000, 16'h8000, 16'h8000},
			'{16'h7fff, 16'h7fff, 16'h7fff}, '{16'h8000, 16'h0000, 16'h0000},
			'{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'h0000, 16'h8000},
			'{16'h7fff, 16'h0000, 16'h0000}, '{16'h0000, 16'h7fff, 16'h0000},
			'{16'h0000, 16'h0000, 16'h7fff}, '{16'h0001, 16'h0000, 16'h0000},
			'{16'hffff, 16'h0000, 16'h0000}, '{16'h0001, 16'h0001, 16'h0001},
			'{16'hffff, 16'hffff, 16'hffff}, '{16'h7fff, 16'h8000, 16'h0001},
			'{16'h8000, 16'h7fff, 16'hffff}, '{16'h0003, 16'h0004, 16'h0000},
			'{16'h0000, 16'h0000, 16'h0000}, '{16'haaaa, 16'h5555, 16'hffff},
			'{16'h5555, 16'haaaa, 16'h0000}, '{16'h0001, 16'h8000, 16'h7fff}
		};
		foreach (corner[i])
			send_sample(corner[i][0], corner[i][1], corner[i][2]);

		for (int n = 0; n < ITEMS; n++) begin
			calm = (n >= 300 && n < 500);
			// Stop the receiver while the sender keeps offering samples.
			if (n == 700)
				hold_req = 1'b1;
			// Let the pipeline drain fully before going on.
			if (n == 1000) begin
				samples.valid <= 1'b0;
				while (board.owed.size() != 0)
					@(posedge clk);
			end
			send_sample(pick_axis(), pick_axis(), pick_axis());
		end
		samples.valid <= 1'b0;

		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0)
			$display("vector3_normalizer test passed");
		else
			$display("vector3_normalizer test failed");
		$finish;
	end

	// Receiver: checks each transfer and stalls at random or on request.
	initial begin
		int held;
		units.ready <= 1'b0;
		held = 0;
		forever begin
			@(posedge clk);
			if (units.valid && units.ready && arst_n)
				board.check_result({units.x, units.y, units.z, units.zero});
			if (hold_req && held < 300) begin
				held++;
				units.ready <= 1'b0;
			end else if (calm) begin
				units.ready <= 1'b1;
			end else begin
				units.ready <= ($urandom_range(99) >= 11);
			end
		end
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("vector3_normalizer test failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/v3n_pkg.sv
rtl/core/v3n_if.sv
rtl/core/v3n_sqrt.sv
rtl/core/v3n_div_lane.sv
rtl/core/vector3_normalizer.sv
dv/vector3_normalizer_test.sv
